### design/cpfl_pkg.sv
package cpfl_pkg;

  // Pool size and the widths that follow from it.
  localparam int NUM_CHUNKS  = 256;
  localparam int IDX_W       = $clog2(NUM_CHUNKS);
  localparam int CNT_W       = $clog2(NUM_CHUNKS + 1);
  localparam int INDEX_LIMIT = (NUM_CHUNKS < 256) ? NUM_CHUNKS : 256;

  // Field and register widths.
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int CINDEX_W = 8;
  localparam int COUNT_W  = 9;
  localparam int UNITS_W  = 13;
  localparam int OFFSET_W = 24;
  localparam int UNIT_SHIFT = 4;
  localparam int PROD_W   = CINDEX_W + UNITS_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);
  localparam logic [UNITS_W-1:0] UNITS_RESET = UNITS_W'(1);
  localparam logic [UNITS_W-1:0] UNITS_MAX   = UNITS_W'(4096);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(INDEX_LIMIT);

  // Actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_UNITS = 1'b1;

  // One link of the free list.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] link;
  } cpfl_link_t;

  // Requests from the controller to the link store.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cpfl_link_t       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rebuild;
    logic [CNT_W-1:0] rebuild_cnt;
  } cpfl_store_req_t;

endpackage

### design/cpfl_link_store.sv
module cpfl_link_store import cpfl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cpfl_store_req_t req,
  output cpfl_link_t      rd_entry
);

  // Link memory with a registered read. An entry that has not been
  // written since the last rebuild reads as the rebuilt chain: entry i links
  // to i-1 when 0 < i < count, and holds no link otherwise.
  cpfl_link_t             mem [NUM_CHUNKS];
  logic [NUM_CHUNKS-1:0]  written_r;
  logic [CNT_W-1:0]       rebuild_cnt_r;
  logic [IDX_W-1:0]       rd_addr_r;
  cpfl_link_t             rdata_r;
  cpfl_link_t             rebuilt;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r   <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r     <= '0;
      rebuild_cnt_r <= CNT_W'(COUNT_LIMIT);
    end else if (req.rebuild) begin
      written_r     <= '0;
      rebuild_cnt_r <= req.rebuild_cnt;
    end else if (req.wr_en) begin
      written_r[req.wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    rebuilt.valid = (rd_addr_r != '0) && ({1'b0, rd_addr_r} < rebuild_cnt_r);
    rebuilt.link  = rebuilt.valid ? (rd_addr_r - IDX_W'(1)) : '0;
    rd_entry      = written_r[rd_addr_r] ? rdata_r : rebuilt;
  end

endmodule

### design/chunk_pool_free_list.sv
// Fixed-size chunk pool allocator built on a last-in first-out free list.
// The input channel (in_valid, in_stall) carries one word per request:
// alloc pops the head chunk, free pushes in_chunk_index after a range check
// against chunk_count, and clear rebuilds the list so that chunks leave in
// descending order. Every request answers with exactly one word on the
// result channel (out_valid, out_stall): a status, and for a successful
// alloc the chunk index and its byte offset (index * chunk_units * 16).
// Free, clear and an empty alloc have their result registered at the
// edge that accepts them. A successful alloc reads the link of the head
// chunk from the synchronous link memory: the request is accepted, and
// the result appears after the read returns. The input stalls during
// that read, so no request follows an alloc until its result is
// registered; other requests go every cycle while the receiver keeps up.
// Clear needs no pass over the memory: per-entry written bits mark which
// links the memory holds, and the others read as the rebuilt chain.
// The result register lets the next request in while a word waits, as long
// as the waiting word is taken in the same cycle; a stalled result holds.
// Reset leaves chunk_count at 256, chunk_units at 1 and the full list with
// chunk 255 at the head; no clearing pass is needed.
// Writes on cfg_we take effect at once; issue them only while idle.
module chunk_pool_free_list import cpfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [CINDEX_W-1:0]  in_chunk_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CINDEX_W-1:0]  out_chunk_index_out,
  output logic [OFFSET_W-1:0]  out_byte_offset,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [UNITS_W-1:0]   cfg_wdata
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t                state_r, state_nxt;
  logic                  head_valid_r, head_valid_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [COUNT_W-1:0]    chunk_count_r;
  logic [UNITS_W-1:0]    chunk_units_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [CINDEX_W-1:0]   out_index_r, out_index_nxt;
  logic [OFFSET_W-1:0]   out_offset_r, out_offset_nxt;

  logic                  in_acc;
  logic [COUNT_W-1:0]    eff_cnt;
  logic [UNITS_W-1:0]    units_sat;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W+UNIT_SHIFT-1:0] offset_full;
  cpfl_store_req_t       store_req;
  cpfl_link_t            rd_entry;

  cpfl_link_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (store_req),
    .rd_entry (rd_entry)
  );

  // A new word is taken only in idle and only when the result register is
  // free or is being emptied in this cycle.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    eff_cnt     = (chunk_count_r > COUNT_LIMIT) ? COUNT_LIMIT : chunk_count_r;
    units_sat   = (chunk_units_r > UNITS_MAX) ? UNITS_MAX : chunk_units_r;
    prod        = PROD_W'(CINDEX_W'(head_r)) * PROD_W'(units_sat);
    offset_full = {prod, {UNIT_SHIFT{1'b0}}};

    state_nxt      = state_r;
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_offset_nxt = out_offset_r;

    store_req             = '0;
    store_req.rebuild_cnt = CNT_W'(eff_cnt);
    store_req.rd_addr     = head_r;
    store_req.wr_addr     = IDX_W'(in_chunk_index);
    store_req.wr_data     = '{valid: head_valid_r, link: head_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_status_nxt = ST_OK;
          out_index_nxt  = '0;
          out_offset_nxt = '0;
          priority if (in_action == ACT_ALLOC) begin
            if (!head_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
            end else begin
              // Fetch the head's link; the result follows the read.
              store_req.rd_en = 1'b1;
              state_nxt       = S_POP;
            end
          end else if (in_action == ACT_FREE) begin
            out_valid_nxt = 1'b1;
            if ({1'b0, in_chunk_index} >= eff_cnt) begin
              out_status_nxt = ST_RANGE;
            end else begin
              store_req.wr_en = 1'b1;
              head_valid_nxt  = 1'b1;
              head_nxt        = IDX_W'(in_chunk_index);
            end
          end else if (in_action == ACT_CLEAR) begin
            out_valid_nxt     = 1'b1;
            store_req.rebuild = 1'b1;
            head_valid_nxt    = (eff_cnt != '0);
            head_nxt          = (eff_cnt != '0) ? IDX_W'(eff_cnt - COUNT_W'(1)) : '0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_index_nxt  = CINDEX_W'(head_r);
        out_offset_nxt = offset_full[OFFSET_W-1:0];
        head_valid_nxt = rd_entry.valid;
        head_nxt       = rd_entry.link;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_valid_r  <= 1'b1;
      head_r        <= IDX_W'(COUNT_LIMIT - COUNT_W'(1));
      chunk_count_r <= COUNT_RESET;
      chunk_units_r <= UNITS_RESET;
      out_valid_r   <= 1'b0;
      out_status_r  <= ST_OK;
      out_index_r   <= '0;
      out_offset_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      head_valid_r <= head_valid_nxt;
      head_r       <= head_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_offset_r <= out_offset_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHUNK_COUNT: chunk_count_r <= cfg_wdata[COUNT_W-1:0];
          CFG_CHUNK_UNITS: chunk_units_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chunk_index_out = out_index_r;
  assign out_byte_offset     = out_offset_r;

  // The result register must be empty when a pop completes.
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !out_valid_r)
    else $error("pop completes while a result is still pending");

  // An alloc on a non-empty list always goes through the read cycle.
  a_alloc_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action == ACT_ALLOC && head_valid_r) |=> (state_r == S_POP))
    else $error("alloc did not enter the read cycle");

  // A free in range puts the chunk at the head of the list.
  a_free_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action == ACT_FREE && ({1'b0, in_chunk_index} < eff_cnt))
    |=> (head_valid_r && head_r == $past(IDX_W'(in_chunk_index))))
    else $error("freed chunk is not the new head");

  // Only a successful alloc reports a chunk.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_index_r == '0 && out_offset_r == '0))
    else $error("failed request reports a chunk");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cpfl_pkg::*;

  // The unused action code answers with status ok and changes nothing.
  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  // Upper bound on the run in clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 240;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CINDEX_W-1:0] cidx;
    logic [OFFSET_W-1:0] off;
  } pool_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // One row of the directed table: a request word, or a pair of register writes.
  typedef struct packed {
    row_kind_t           kind;
    logic [ACTION_W-1:0] act;
    logic [CINDEX_W-1:0] idx;
    logic                pinned;
    pool_result_t        res;
    logic [COUNT_W-1:0]  cnt;
    logic [UNITS_W-1:0]  units;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ACTION_W-1:0]  in_action;
  logic [CINDEX_W-1:0]  in_chunk_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [CINDEX_W-1:0]  out_chunk_index_out;
  logic [OFFSET_W-1:0]  out_byte_offset;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [UNITS_W-1:0]   cfg_wdata;

  chunk_pool_free_list uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_chunk_index      (in_chunk_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_chunk_index_out (out_chunk_index_out),
    .out_byte_offset     (out_byte_offset),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the pool: the register values, the head of the free list
  // and one next link per chunk, each with a valid bit.
  logic [COUNT_W-1:0] pool_count;
  logic [UNITS_W-1:0] pool_units;
  logic               head_ok;
  logic [IDX_W-1:0]   head_idx;
  logic               link_ok [NUM_CHUNKS];
  logic [IDX_W-1:0]   link_nx [NUM_CHUNKS];

  // Results that are owed by the block, oldest first.
  pool_result_t       pending_results [$];
  // Chunks currently handed out, so that most frees give back a real chunk.
  logic [CINDEX_W-1:0] chunks_out [$];
  stim_row_t          stim_tbl [$];

  // A directed row may carry a result typed in by hand; the sender posts it
  // here and the monitor queues it in place of the predicted one.
  bit                 pin_on;
  pool_result_t       pin_res;

  int                 mismatches;
  int                 cycles;
  bit                 tx_quiet;
  bit                 rx_quiet;

  function automatic logic [COUNT_W-1:0] usable_count();
    return (pool_count > COUNT_LIMIT) ? COUNT_LIMIT : pool_count;
  endfunction

  // Relink the whole pool so that the top chunk leaves first and chunk 0 last.
  function automatic void pool_rebuild();
    logic [COUNT_W-1:0] c;
    c = usable_count();
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      link_ok[i] = (i >= 1) && (i < int'(c));
      link_nx[i] = (i >= 1) ? IDX_W'(i - 1) : '0;
    end
    head_ok  = (c != 0);
    head_idx = (c != 0) ? IDX_W'(c - 1) : '0;
  endfunction

  // Apply one request word to the shadow pool and return the word it answers with.
  function automatic pool_result_t pool_step(input logic [ACTION_W-1:0] act,
                                             input logic [CINDEX_W-1:0] ci);
    pool_result_t       r;
    logic [UNITS_W-1:0] u;
    logic [31:0]        prod;
    r = '0;
    case (act)
      ACT_ALLOC: begin
        if (!head_ok) begin
          r.status = ST_EMPTY;
        end else begin
          u      = (pool_units > UNITS_MAX) ? UNITS_MAX : pool_units;
          prod   = 32'(head_idx) * 32'(u);
          r.cidx = CINDEX_W'(head_idx);
          r.off  = OFFSET_W'(prod << UNIT_SHIFT);
          head_ok  = link_ok[head_idx];
          head_idx = link_nx[head_idx];
        end
      end
      ACT_FREE: begin
        if (COUNT_W'(ci) >= usable_count()) begin
          r.status = ST_RANGE;
        end else begin
          // Double frees go through unchecked, just as in the block.
          link_ok[ci] = head_ok;
          link_nx[ci] = head_idx;
          head_ok     = 1'b1;
          head_idx    = IDX_W'(ci);
        end
      end
      ACT_CLEAR: begin
        pool_rebuild();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void add_word(input logic [ACTION_W-1:0] act,
                                   input logic [CINDEX_W-1:0] ci,
                                   input logic pinned, input pool_result_t res);
    stim_row_t row;
    row        = '0;
    row.kind   = ROW_WORD;
    row.act    = act;
    row.idx    = ci;
    row.pinned = pinned;
    row.res    = res;
    stim_tbl.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [COUNT_W-1:0] cnt,
                                  input logic [UNITS_W-1:0] units);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.cnt   = cnt;
    row.units = units;
    stim_tbl.push_back(row);
  endfunction

  // Offer one word after a random gap and return at the edge that takes it.
  // Every word of the run, directed or random, goes through here.
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [CINDEX_W-1:0] ci,
                           input logic pinned, input pool_result_t res);
    int gap;
    if ($urandom_range(0, 29) == 0) begin
      tx_quiet = !tx_quiet;
    end
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_action      <= act;
    in_chunk_index <= ci;
    pin_on  = pinned;
    pin_res = res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back. Each word
  // answers with exactly one result, so nothing can still be in flight then.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Both registers go in on back-to-back edges while the block is idle.
  task automatic write_regs(input logic [COUNT_W-1:0] cnt, input logic [UNITS_W-1:0] units);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHUNK_COUNT;
    cfg_wdata <= UNITS_W'(cnt);
    @(negedge clk);
    cfg_index <= CFG_CHUNK_UNITS;
    cfg_wdata <= units;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Monitor. Everything is sampled at the rising edge, where the block's
  // outputs still hold their values from before the edge. The result side
  // is checked before the request side is predicted: a result taken at this
  // edge always belongs to a request taken at an earlier one.
  always @(posedge clk) begin : monitor
    pool_result_t e;
    pool_result_t r;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_CHUNK_COUNT) begin
          pool_count = cfg_wdata[COUNT_W-1:0];
        end else begin
          pool_units = cfg_wdata;
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected: status %0d index %0d offset %0d",
                   $time, out_status, out_chunk_index_out, out_byte_offset);
          mismatches++;
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d, got %0d", $time, e.status, out_status);
            mismatches++;
          end
          if (out_chunk_index_out !== e.cidx) begin
            $display("%0t: chunk index expected %0d, got %0d",
                     $time, e.cidx, out_chunk_index_out);
            mismatches++;
          end
          if (out_byte_offset !== e.off) begin
            $display("%0t: byte offset expected %0d, got %0d",
                     $time, e.off, out_byte_offset);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        r = pool_step(in_action, in_chunk_index);
        if (in_action == ACT_ALLOC && r.status == ST_OK) begin
          chunks_out.push_back(r.cidx);
        end
        if (in_action == ACT_CLEAR) begin
          chunks_out.delete();
        end
        pending_results.push_back(pin_on ? pin_res : r);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver. Before each result it holds stall high for a random number of
  // cycles, with runs of no stalling at all. Twice it holds off for a long
  // stretch, so that the block fills up and has to stall the request side.
  initial begin : receiver
    int hold;
    int words_taken;
    words_taken = 0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        rx_quiet = !rx_quiet;
      end
      hold = rx_quiet ? 0 : $urandom_range(0, 17);
      if (words_taken == 500 || words_taken == 1300) begin
        hold = 300;
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin : stimulus
    int                  p;
    int                  n;
    int                  r;
    int                  aw;
    int                  k;
    logic [ACTION_W-1:0] act;
    logic [CINDEX_W-1:0] ci;
    logic [COUNT_W-1:0]  ph_count [RAND_PHASES];
    logic [UNITS_W-1:0]  ph_units [RAND_PHASES];
    stim_row_t           row;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_ALLOC;
    in_chunk_index = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_CHUNK_COUNT;
    cfg_wdata      = '0;
    pin_on         = 1'b0;
    pin_res        = '0;
    mismatches     = 0;
    cycles         = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;

    // Shadow pool starts from the reset state: 256 chunks of 16 bytes, chunk 255 on top.
    pool_count = COUNT_RESET;
    pool_units = UNITS_RESET;
    pool_rebuild();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Right after reset the list is full, so allocs come out
    // from the top and a freed chunk is the next one handed back.
    add_word(ACT_ALLOC, 8'hFF, 1'b1, '{ST_OK, 8'd255, 24'd4080});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd254, 24'd4064});
    add_word(ACT_FREE,  8'hFF, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd255, 24'd4080});
    // Chunk 0 is still on the list, so this is a double free that goes through.
    add_word(ACT_FREE,  8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_NOP,   8'hAA, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_CLEAR, 8'h55, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd255, 24'd4080});
    // A one-chunk pool of the largest size: one alloc, then it is empty.
    add_cfg(9'd1, 13'd4096);
    add_word(ACT_CLEAR, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_EMPTY, 8'd0, 24'd0});
    add_word(ACT_FREE,  8'h01, 1'b1, '{ST_RANGE, 8'd0, 24'd0});
    add_word(ACT_FREE,  8'hFF, 1'b1, '{ST_RANGE, 8'd0, 24'd0});
    add_word(ACT_FREE,  8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    // Full pool of the largest chunks gives the largest offset.
    add_cfg(9'd256, 13'd4096);
    add_word(ACT_CLEAR, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd255, 24'd16711680});
    add_word(ACT_ALLOC, 8'h00, 1'b0, '0);
    add_word(ACT_FREE,  8'hFF, 1'b1, '{ST_OK, 8'd0, 24'd0});
    // A zero count does not drain the list until the next clear, and a
    // zero chunk size puts every chunk at offset zero.
    add_cfg(9'd0, 13'd0);
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd255, 24'd0});
    add_word(ACT_FREE,  8'h00, 1'b1, '{ST_RANGE, 8'd0, 24'd0});
    add_word(ACT_CLEAR, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_EMPTY, 8'd0, 24'd0});
    // Register values past the top saturate: 256 chunks of 4096 units.
    add_cfg(9'd511, 13'd8191);
    add_word(ACT_CLEAR, 8'h00, 1'b1, '{ST_OK, 8'd0, 24'd0});
    add_word(ACT_ALLOC, 8'h00, 1'b1, '{ST_OK, 8'd255, 24'd16711680});
    add_word(ACT_FREE,  8'h80, 1'b0, '0);

    foreach (stim_tbl[i]) begin
      row = stim_tbl[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_regs(row.cnt, row.units);
      end else begin
        send_word(row.act, row.idx, row.pinned, row.res);
      end
    end

    // Random part. Each phase runs under its own register setting, mostly
    // starting from a fresh list. Most frees give back a chunk that is out,
    // so the list stays well formed; the rest are stray or double frees,
    // clears and unused actions. The alloc share varies per phase so that
    // small pools run dry and large ones fill back up.
    ph_count[0] = 9'd256;
    ph_count[1] = 9'd1;
    ph_count[2] = 9'd2;
    ph_count[3] = COUNT_W'($urandom_range(3, 255));
    ph_count[4] = 9'd0;
    ph_count[5] = COUNT_W'($urandom_range(257, 511));
    ph_count[6] = COUNT_W'($urandom_range(1, 16));
    ph_count[7] = 9'd256;
    ph_units[0] = 13'd1;
    ph_units[1] = 13'd4096;
    ph_units[2] = 13'd0;
    ph_units[3] = 13'd8191;
    ph_units[4] = UNITS_W'($urandom_range(2, 4095));
    ph_units[5] = 13'd4097;
    ph_units[6] = UNITS_W'($urandom_range(0, 8191));
    ph_units[7] = UNITS_W'($urandom_range(1, 64));

    for (p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      write_regs(ph_count[p], ph_units[p]);
      aw = $urandom_range(30, 70);
      if ($urandom_range(0, 4) != 0) begin
        send_word(ACT_CLEAR, CINDEX_W'($urandom), 1'b0, '0);
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        r  = $urandom_range(0, 99);
        ci = CINDEX_W'($urandom);
        if (r < aw) begin
          act = ACT_ALLOC;
        end else if (r < 90) begin
          act = ACT_FREE;
          if (chunks_out.size() != 0) begin
            k  = $urandom_range(0, chunks_out.size() - 1);
            ci = chunks_out[k];
            chunks_out.delete(k);
          end
        end else if (r < 95) begin
          act = ACT_FREE;
        end else if (r < 97) begin
          act = ACT_CLEAR;
        end else begin
          act = ACT_NOP;
        end
        send_word(act, ci, 1'b0, '0);
      end
    end

    // Let the last results drain, then keep the clock running for anything stray.
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/cpfl_pkg.sv
design/cpfl_link_store.sv
design/chunk_pool_free_list.sv
verif/tb_top.sv
